FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// clocked property checks, with and without a reset qualifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is held
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the sorted priority queue
// operation codes and the control word broadcast to every cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    // operation codes carried in tuser of an input item
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // control word broadcast along the cell chain
    typedef struct packed {
        logic ins;  // insert that will be done this cycle
        logic rem;  // remove that will be done this cycle
    } t_cell_ctrl;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// holds a tag and a priority; keeps, loads the new entry or shifts by one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell #(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_valid,      // slot lies below the count
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic                  i_prev_ge,    // slot nearer the head keeps its entry
    input  logic [TAG_BITS-1:0]   i_prev_tag,
    input  logic [PRIO_BITS-1:0]  i_prev_prio,
    input  logic [TAG_BITS-1:0]   i_next_tag,
    input  logic [PRIO_BITS-1:0]  i_next_prio,
    output logic                  o_ge,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic [TAG_BITS-1:0]   o_n_tag,
    output logic [PRIO_BITS-1:0]  o_n_prio
);

    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  n_tag;
    logic [PRIO_BITS-1:0] n_prio;

    // stored entry stays ahead of the new one on equal or higher priority
    assign o_ge = i_valid && (r_prio >= i_new_prio);

    // next slot contents
    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctrl.ins) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    n_tag  = i_new_tag;
                    n_prio = i_new_prio;
                end else begin
                    n_tag  = i_prev_tag;
                    n_prio = i_prev_prio;
                end
            end
        end else if (i_ctrl.rem) begin
            n_tag  = i_next_tag;
            n_prio = i_next_prio;
        end
    end

    // slot register, payload only
    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

    assign o_tag    = r_tag;
    assign o_prio   = r_prio;
    assign o_n_tag  = n_tag;
    assign o_n_prio = n_prio;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue in a row of cells
// insert or remove one item per cycle unless the output stalls, result with head and occupancy
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle, insert or remove. The result of an
// item is loaded into the output register at the edge that accepts the item
// and is offered from the next cycle on, held there until taken. A new item
// is accepted in the same cycle as the waiting result is taken. While a result
// waits and the receiver holds off, the input stalls. With the receiver always
// ready the sustained rate is one item every cycle. The rate is set by the row
// of DEPTH cells: every cell compares its own priority with the new one and
// decides locally whether to keep, load or shift. The head is always cell 0.
// Equal priorities leave in arrival order. After reset the queue is empty at
// once, with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 16,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IN_W     = ((TAG_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int OUT_RAW  = 1 + TAG_BITS + PRIO_BITS + CNT_W + 2,
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // tag, priority_req
    input  logic             i_s_axis_tuser,   // op
    // result items
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // accepted, head_tag, head_priority,
                                               // occupancy, is_empty, is_full
);

    localparam int TAG_LO  = 1;
    localparam int PRIO_LO = TAG_LO + TAG_BITS;
    localparam int OCC_LO  = PRIO_LO + PRIO_BITS;
    localparam int EMP_BIT = OCC_LO + CNT_W;
    localparam int FUL_BIT = EMP_BIT + 1;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic [OUT_W-1:0]     n_out_data;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_done;
    logic [TAG_BITS-1:0]  w_new_tag;
    logic [PRIO_BITS-1:0] w_new_prio;
    spq_pkg::t_cell_ctrl  w_ctrl;

    logic                 w_ge     [DEPTH];
    logic [TAG_BITS-1:0]  w_tag    [DEPTH];
    logic [PRIO_BITS-1:0] w_prio   [DEPTH];
    logic [TAG_BITS-1:0]  w_n_tag  [DEPTH];
    logic [PRIO_BITS-1:0] w_n_prio [DEPTH];

    // input handshake and field split
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_new_tag       = i_s_axis_tdata[TAG_BITS-1:0];
    assign w_new_prio      = i_s_axis_tdata[TAG_BITS +: PRIO_BITS];

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // operation decode, rejected items leave the cells alone
    always_comb begin
        w_ctrl.ins = w_accept && (i_s_axis_tuser == spq_pkg::OP_INSERT) && !w_full;
        w_ctrl.rem = w_accept && (i_s_axis_tuser == spq_pkg::OP_REMOVE) && !w_empty;
    end
    assign w_done = w_ctrl.ins || w_ctrl.rem;

    // cell row, head in cell 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                 w_valid;
        logic                 w_prev_ge;
        logic [TAG_BITS-1:0]  w_prev_tag;
        logic [PRIO_BITS-1:0] w_prev_prio;
        logic [TAG_BITS-1:0]  w_next_tag;
        logic [PRIO_BITS-1:0] w_next_prio;

        assign w_valid = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign w_prev_ge   = 1'b1;
            assign w_prev_tag  = w_new_tag;
            assign w_prev_prio = w_new_prio;
        end else begin : g_inner
            assign w_prev_ge   = w_ge[gi-1];
            assign w_prev_tag  = w_tag[gi-1];
            assign w_prev_prio = w_prio[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next_tag  = w_tag[gi];
            assign w_next_prio = w_prio[gi];
        end else begin : g_body
            assign w_next_tag  = w_tag[gi+1];
            assign w_next_prio = w_prio[gi+1];
        end

        spq_cell #(
            .TAG_BITS  (TAG_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_valid     (w_valid),
            .i_new_tag   (w_new_tag),
            .i_new_prio  (w_new_prio),
            .i_prev_ge   (w_prev_ge),
            .i_prev_tag  (w_prev_tag),
            .i_prev_prio (w_prev_prio),
            .i_next_tag  (w_next_tag),
            .i_next_prio (w_next_prio),
            .o_ge        (w_ge[gi]),
            .o_tag       (w_tag[gi]),
            .o_prio      (w_prio[gi]),
            .o_n_tag     (w_n_tag[gi]),
            .o_n_prio    (w_n_prio[gi])
        );
    end

    // occupancy after the item
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // result word from the state after the item
    always_comb begin
        n_out_data = '0;
        n_out_data[0] = w_done;
        if (n_count != '0) begin
            n_out_data[TAG_LO +: TAG_BITS]   = w_n_tag[0];
            n_out_data[PRIO_LO +: PRIO_BITS] = w_n_prio[0];
        end
        n_out_data[OCC_LO +: CNT_W] = n_count;
        n_out_data[EMP_BIT]         = (n_count == '0);
        n_out_data[FUL_BIT]         = (n_count == CNT_W'(DEPTH));
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || (r_count <= CNT_W'(DEPTH)), "count beyond depth")
    `ASSERT_RST(a_remove_count, i_clk, i_rst_n, w_ctrl.rem |=> r_count == $past(r_count) - CNT_W'(1), "remove did not drop count")
    `ASSERT_RST(a_reject_full, i_clk, i_rst_n, (w_accept && i_s_axis_tuser == spq_pkg::OP_INSERT && w_full) |=> $stable(r_count), "insert while full changed count")
    `ASSERT_RST(a_head_order, i_clk, i_rst_n, (r_count >= CNT_W'(2)) |-> (w_prio[0] >= w_prio[1]), "head not highest priority")

endmodule
